// ===== rtl/lrt_pkg.sv =====
`default_nettype none

package lrt_pkg;

    parameter int unsigned MAX_STRING_LENGTH = 65535;

    localparam int CharW  = 8;
    localparam int LenW   = 16;
    localparam int TableN = 1 << CharW;

    // lengths saturate at the smaller of the string limit and the counter range
    localparam logic [LenW-1:0] LenLimit =
        LenW'((MAX_STRING_LENGTH < 65535) ? MAX_STRING_LENGTH : 65535);

    typedef logic [CharW-1:0] t_char;
    typedef logic [LenW-1:0]  t_len;

    // update of the per-character seen flags
    typedef struct packed {
        logic  clear;
        logic  set;
        t_char set_idx;
    } t_seen_ctl;

endpackage

`default_nettype wire

// ===== rtl/lrt_in_if.sv =====
`default_nettype none

interface lrt_in_if;
    import lrt_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_in;
    logic  end_of_string;

    modport source (output valid, output char_in, output end_of_string, input ready);
    modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrt_out_if.sv =====
`default_nettype none

interface lrt_out_if;
    import lrt_pkg::*;

    logic valid;
    logic ready;
    t_len window_length;
    t_len best_length;
    logic final_result;
    logic overflow;

    modport source (output valid, output window_length, output best_length,
                    output final_result, output overflow, input ready);
    modport sink   (input valid, input window_length, input best_length,
                    input final_result, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/longest_distinct_run_tracker.sv =====
`default_nettype none

// Longest repeat-free run tracker. Bytes of a string arrive one per transfer
// on i_in, the final byte flagged by end_of_string; each byte gives one result
// on o_out with the length of the repeat-free window ending at it, the best
// such length so far in the string, the echoed final flag and an overflow flag.
// The block takes one byte per clock cycle as long as o_out is drained; a
// result passes from the stage-1 register (table read on the accepting edge)
// to the output register (update from the read entry). The rate is set by
// the last-position table, a 256-entry memory with a registered read,
// whose read-modify-write is closed by forwarding the position written by the
// previous byte. Seen flags sit in flip-flops, so no clearing pass follows
// reset or the end of a string. Once a string reaches the length limit, the
// remaining bytes report the limit in both length fields with overflow set and
// leave the string state alone, but for the final byte, which clears it.
module longest_distinct_run_tracker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    lrt_in_if.sink   i_in,
    lrt_out_if.source o_out
);
    import lrt_pkg::*;

    // stage 1: byte whose table entry is being read
    logic      r_s1_valid;
    t_char     r_s1_char;
    logic      r_s1_eos;
    logic      r_fwd_hit;
    t_len      r_fwd_pos;
    t_len      ram_rd;

    // string state
    t_len      r_pos;
    t_len      r_start;
    t_len      r_best;
    logic      r_ovf;

    // output register
    logic      r_out_valid;
    t_len      r_out_wl;
    t_len      r_out_best;
    logic      r_out_final;
    logic      r_out_ovf;

    logic      s1_adv;
    logic      in_fire;
    logic      seen_bit;
    logic      ovf_now;
    logic      hit;
    logic      wr_en;
    t_len      last_pos;
    t_len      n_start;
    t_len      wl;
    t_len      n_best;
    t_seen_ctl seen_ctl;

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign in_fire     = i_in.valid && i_in.ready;

    assign ovf_now  = r_ovf || (r_pos >= LenLimit);
    assign last_pos = r_fwd_hit ? r_fwd_pos : ram_rd;
    assign hit      = seen_bit && (last_pos >= r_start);
    assign n_start  = hit ? last_pos + 1'b1 : r_start;
    assign wl       = r_pos - n_start + 1'b1;
    assign n_best   = (wl > r_best) ? wl : r_best;
    assign wr_en    = s1_adv && !ovf_now;

    always_comb begin
        seen_ctl.clear   = s1_adv && r_s1_eos;
        seen_ctl.set     = wr_en;
        seen_ctl.set_idx = r_s1_char;
    end

    lrt_pos_ram #(
        .Depth (TableN),
        .Width (LenW)
    ) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_char),
        .i_wr_data (r_pos),
        .i_rd_en   (in_fire),
        .i_rd_addr (i_in.char_in),
        .o_rd_data (ram_rd)
    );

    lrt_seen_bits u_seen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (seen_ctl),
        .i_rd_idx (r_s1_char),
        .o_rd_bit (seen_bit)
    );

    // stage 1 capture; the read misses a write landing on the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (in_fire) begin
            r_s1_char <= i_in.char_in;
            r_s1_eos  <= i_in.end_of_string;
            r_fwd_hit <= wr_en && (r_s1_char == i_in.char_in);
            r_fwd_pos <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_best  <= '0;
            r_ovf   <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1_eos) begin
                r_pos   <= '0;
                r_start <= '0;
                r_best  <= '0;
                r_ovf   <= 1'b0;
            end else if (ovf_now) begin
                r_ovf <= 1'b1;
            end else begin
                r_pos   <= r_pos + 1'b1;
                r_start <= n_start;
                r_best  <= n_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv) begin
            r_out_wl    <= ovf_now ? LenLimit : wl;
            r_out_best  <= ovf_now ? LenLimit : n_best;
            r_out_final <= r_s1_eos;
            r_out_ovf   <= ovf_now;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.window_length = r_out_wl;
    assign o_out.best_length   = r_out_best;
    assign o_out.final_result  = r_out_final;
    assign o_out.overflow      = r_out_ovf;

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_eos |=> r_pos == '0 && r_start == '0 && !r_ovf)
        else $error("string state not cleared after final byte");

    a_start_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start <= r_pos)
        else $error("window start passed position");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && !r_s1_eos && !ovf_now |=> r_pos == $past(r_pos) + 1'b1)
        else $error("position did not advance by one");

    a_wl_le_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_wl <= r_out_best && r_out_wl != '0)
        else $error("window length exceeds best length");

    a_ovf_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> !wr_en)
        else $error("table written after overflow");

endmodule

`default_nettype wire

// ===== rtl/lrt_pos_ram.sv =====
`default_nettype none

module lrt_pos_ram #(
    parameter int Depth = 256,
    parameter int Width = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(Depth)-1:0] i_wr_addr,
    input  wire logic [Width-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic      [Width-1:0]         o_rd_data
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lrt_seen_bits.sv =====
`default_nettype none

module lrt_seen_bits (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lrt_pkg::t_seen_ctl i_ctl,
    input  wire lrt_pkg::t_char     i_rd_idx,
    output logic                    o_rd_bit
);
    import lrt_pkg::*;

    logic [TableN-1:0] r_seen;

    // clear wins over set: the final byte of a string leaves nothing behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_seen <= '0;
        end else if (i_ctl.set) begin
            r_seen[i_ctl.set_idx] <= 1'b1;
        end
    end

    assign o_rd_bit = r_seen[i_rd_idx];

endmodule

`default_nettype wire
